@@ hw/rtl/npld_pkg.sv @@
// ----------------------------------------------------------------------------
// npld_pkg
// Types, constants and the opcode pattern tables for the next-pc and
// instruction length decoder.
// ----------------------------------------------------------------------------
package npld_pkg;

    localparam int ADDR_BITS = 24;
    localparam int PC_W      = 24;
    localparam int NEXT_W    = 24;

    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef enum logic [2:0] {
        KIND_RESOLVED = 3'd0,
        KIND_REGISTER = 3'd1,
        KIND_VECTOR   = 3'd2,
        KIND_RETURN   = 3'd3,
        KIND_UNDECODE = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        JT_NONE = 3'd0,
        JT_ABS  = 3'd1,
        JT_IND  = 3'd2,
        JT_RET  = 3'd3,
        JT_REG  = 3'd4,
        JT_RELB = 3'd5,
        JT_RELW = 3'd6
    } jump_t;

    localparam logic [7:0] OP_BSR_BYTE = 8'h55;
    localparam logic [7:0] OP_BSR_WORD = 8'h5c;

    typedef struct packed {
        logic [PC_W-1:0] pc_address;
        logic [31:0]     instruction_bytes;
        logic [7:0]      ccr;
    } in_word_t;

    typedef struct packed {
        kind_t             target_kind;
        logic [NEXT_W-1:0] next_address;
        logic [2:0]        register_index;
        logic [7:0]        vector_address;
        logic              branch_taken;
        logic [2:0]        length_words;
    } out_word_t;

    // len >= 0: length in words; len < 0: minus the next table number
    typedef struct packed {
        logic              hit;
        logic signed [3:0] len;
        jump_t             jt;
    } entry_t;

    localparam logic [6:0] COND_SEL [8] = '{
        7'h00, 7'h40, 7'h01, 7'h04, 7'h02, 7'h08, 7'h10, 7'h20
    };

    function automatic logic pm(input logic [7:0] b, input logic [7:0] pat,
                                input logic [7:0] msk);
        return (b & msk) == pat;
    endfunction

    function automatic entry_t mk(input logic signed [3:0] len, input jump_t jt);
        entry_t e;
        e.hit = 1'b1;
        e.len = len;
        e.jt  = jt;
        return e;
    endfunction

    // first matching entry wins
    function automatic entry_t find_entry(input logic [2:0] t, input logic [7:0] b);
        entry_t e;
        e = '{hit: 1'b0, len: 4'sd0, jt: JT_NONE};
        unique case (t)
            3'd0:
            begin
                priority if (pm(b, 8'h00, 8'hff)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h01, 8'hff)) e = mk(-4'sd1, JT_NONE);
                else if (pm(b, 8'h02, 8'hfe)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h04, 8'hee)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h06, 8'hfe)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h08, 8'hea)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h0a, 8'hee)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h0e, 8'hee)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h10, 8'hfc)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h16, 8'hfe)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h20, 8'he0)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h40, 8'hf0)) e = mk( 4'sd1, JT_RELB);
                else if (pm(b, 8'h50, 8'hfc)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h54, 8'hfd)) e = mk( 4'sd1, JT_RET);
                else if (pm(b, 8'h55, 8'hff)) e = mk( 4'sd1, JT_RELB);
                else if (pm(b, 8'h57, 8'hff)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h58, 8'hfb)) e = mk( 4'sd2, JT_RELW);
                else if (pm(b, 8'h59, 8'hfb)) e = mk( 4'sd1, JT_REG);
                else if (pm(b, 8'h5a, 8'hfb)) e = mk( 4'sd2, JT_ABS);
                else if (pm(b, 8'h5b, 8'hfb)) e = mk( 4'sd2, JT_IND);
                else if (pm(b, 8'h60, 8'he8)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h68, 8'hfa)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'h6a, 8'hfe)) e = mk(-4'sd2, JT_NONE);
                else if (pm(b, 8'h6e, 8'hfe)) e = mk( 4'sd2, JT_NONE);
                else if (pm(b, 8'h78, 8'hff)) e = mk( 4'sd4, JT_NONE);
                else if (pm(b, 8'h79, 8'hff)) e = mk( 4'sd2, JT_NONE);
                else if (pm(b, 8'h7a, 8'hff)) e = mk( 4'sd3, JT_NONE);
                else if (pm(b, 8'h7b, 8'hff)) e = mk( 4'sd2, JT_NONE);
                else if (pm(b, 8'h7c, 8'hfc)) e = mk( 4'sd2, JT_NONE);
                else if (pm(b, 8'h80, 8'h80)) e = mk( 4'sd1, JT_NONE);
                else e.hit = 1'b0;
            end
            3'd1:
            begin
                priority if (pm(b, 8'h00, 8'hff)) e = mk(-4'sd3, JT_NONE);
                else if (pm(b, 8'h40, 8'hf0)) e = mk(-4'sd3, JT_NONE);
                else if (pm(b, 8'h80, 8'hf0)) e = mk( 4'sd1, JT_NONE);
                else if (pm(b, 8'hc0, 8'hc0)) e = mk( 4'sd2, JT_NONE);
                else e.hit = 1'b0;
            end
            3'd2:
            begin
                priority if (pm(b, 8'h00, 8'h20)) e = mk(4'sd2, JT_NONE);
                else if (pm(b, 8'h20, 8'h20)) e = mk(4'sd3, JT_NONE);
                else e.hit = 1'b0;
            end
            3'd3:
            begin
                priority if (pm(b, 8'h69, 8'hfb)) e = mk( 4'sd2, JT_NONE);
                else if (pm(b, 8'h6b, 8'hff)) e = mk(-4'sd4, JT_NONE);
                else if (pm(b, 8'h6f, 8'hff)) e = mk( 4'sd3, JT_NONE);
                else if (pm(b, 8'h78, 8'hff)) e = mk( 4'sd5, JT_NONE);
                else e.hit = 1'b0;
            end
            3'd4:
            begin
                priority if (pm(b, 8'h00, 8'h78)) e = mk(4'sd3, JT_NONE);
                else if (pm(b, 8'h20, 8'h78)) e = mk(4'sd4, JT_NONE);
                else e.hit = 1'b0;
            end
            default:
            begin
                e.hit = 1'b0;
            end
        endcase
        return e;
    endfunction

    // walk the prefix chain, at most four bytes deep
    function automatic entry_t decode_entry(input logic [31:0] ib);
        entry_t     e;
        entry_t     res;
        logic [2:0] t;
        logic       done;
        logic [7:0] b;
        res  = '{hit: 1'b0, len: 4'sd0, jt: JT_NONE};
        t    = 3'd0;
        done = 1'b0;
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            if (!done)
            begin
                b = 8'(ib >> (24 - 8 * lvl));
                e = find_entry(t, b);
                if (!e.hit)
                begin
                    done = 1'b1;
                end
                else if (e.len < 0)
                begin
                    t = 3'(-e.len);
                end
                else
                begin
                    res  = e;
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic logic cond_holds(input logic [3:0] code, input logic [7:0] ccr);
        logic       nv;
        logic [6:0] syn;
        logic [6:0] m;
        nv  = ccr[3] ^ ccr[1];
        syn = {ccr[2] | ccr[0], nv | ccr[2], nv, ccr[3:0]};
        m   = syn & COND_SEL[code[3:1]];
        return code[0] ? (m != 7'd0) : (m == 7'd0);
    endfunction

endpackage

@@ hw/rtl/next_pc_length_branch_decoder.sv @@
// an accepted input word passes through the input register and then the result register
// throughput: one word per cycle while the result is not stalled; the table walk and
// the next-address adders sit between the input register and the result register
// a stalled result holds in its register while the input register still fills
// reset: rst_n asynchronous, active low, empties both register stages
// ----------------------------------------------------------------------------
// next_pc_length_branch_decoder
// Decodes instruction length and next fetch address, resolving relative
// branches from the condition codes.
// ----------------------------------------------------------------------------
module next_pc_length_branch_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  npld_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output npld_pkg::out_word_t out_data
);
    import npld_pkg::*;

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t out_word_next;

    logic      out_load;
    logic      in_load;

    entry_t      ent;
    logic [31:0] ib;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] w1;
    addr_t       pc;
    addr_t       offset;
    addr_t       sum;
    logic        taken;

    assign out_load  = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || out_load;
    assign in_load   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_comb
    begin
        ib     = in_word_reg.instruction_bytes;
        b0     = ib[31:24];
        b1     = ib[23:16];
        w1     = ib[15:0];
        pc     = ADDR_BITS'(in_word_reg.pc_address);
        ent    = decode_entry(ib);
        taken  = 1'b0;
        offset = ADDR_BITS'({3'(ent.len), 1'b0});

        out_word_next                = '0;
        out_word_next.target_kind    = KIND_UNDECODE;

        if (ent.jt == JT_RELB)
        begin
            taken  = (b0 == OP_BSR_BYTE) || cond_holds(b0[3:0], in_word_reg.ccr);
            offset = taken ? addr_t'({{(ADDR_BITS-8){b1[7]}}, b1}) + addr_t'(2)
                           : addr_t'(2);
        end
        else if (ent.jt == JT_RELW)
        begin
            taken  = (b0 == OP_BSR_WORD) || cond_holds(b1[7:4], in_word_reg.ccr);
            offset = taken ? addr_t'({{(ADDR_BITS-16){w1[15]}}, w1}) + addr_t'(4)
                           : addr_t'(4);
        end
        sum = pc + offset;

        if (ent.hit)
        begin
            out_word_next.target_kind  = KIND_RESOLVED;
            out_word_next.length_words = 3'(ent.len);
            unique case (ent.jt)
                JT_ABS:
                begin
                    out_word_next.next_address = NEXT_W'(ADDR_BITS'(ib));
                end
                JT_IND:
                begin
                    out_word_next.target_kind    = KIND_VECTOR;
                    out_word_next.vector_address = b1;
                end
                JT_RET:
                begin
                    out_word_next.target_kind = KIND_RETURN;
                end
                JT_REG:
                begin
                    out_word_next.target_kind    = KIND_REGISTER;
                    out_word_next.register_index = b1[6:4];
                end
                JT_RELB, JT_RELW:
                begin
                    out_word_next.branch_taken = taken;
                    out_word_next.next_address = NEXT_W'(sum);
                end
                default:
                begin
                    out_word_next.next_address = NEXT_W'(sum);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_word_reg <= in_data;
        end
        if (out_load && in_valid_reg)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

@@ hw/rtl/npld_checker.sv @@
// ----------------------------------------------------------------------------
// npld_checker
// Port-level checks on the next-pc decoder, bound to the top level.
// ----------------------------------------------------------------------------
module npld_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input npld_pkg::out_word_t out_data
);
    import npld_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // an accepted word reaches the output when out_ready lets it into the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted word did not reach the output");

    a_undecodable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.target_kind == KIND_UNDECODE |->
            out_data.length_words == 3'd0 && out_data.next_address == '0 &&
            !out_data.branch_taken)
        else $error("undecodable result carries data");

    a_taken_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.branch_taken |->
            out_data.target_kind == KIND_RESOLVED &&
            (out_data.length_words == 3'd1 || out_data.length_words == 3'd2))
        else $error("taken branch on a non-branch result");

endmodule

bind next_pc_length_branch_decoder npld_checker u_npld_checker (.*);

@@ bench/next_pc_length_branch_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// next_pc_length_branch_decoder_tb
// Drives instruction words through the next-pc decoder and checks each result
// word against a table-driven prediction of length, kind, next address and more.
// ----------------------------------------------------------------------------
module next_pc_length_branch_decoder_tb;

    import npld_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_WORDS = 450;
    localparam int QUIET_TAIL   = 60;
    localparam int SETTLE       = 8;
    localparam int NUM_ROWS     = 42;

    // row: {table, pattern, mask, length or minus next table, jump type}
    localparam logic [25:0] OPCODE_ROWS [NUM_ROWS] = '{
        {3'd0, 8'h00, 8'hff,  4'sd1, JT_NONE}, {3'd0, 8'h01, 8'hff, -4'sd1, JT_NONE},
        {3'd0, 8'h02, 8'hfe,  4'sd1, JT_NONE}, {3'd0, 8'h04, 8'hee,  4'sd1, JT_NONE},
        {3'd0, 8'h06, 8'hfe,  4'sd1, JT_NONE}, {3'd0, 8'h08, 8'hea,  4'sd1, JT_NONE},
        {3'd0, 8'h0a, 8'hee,  4'sd1, JT_NONE}, {3'd0, 8'h0e, 8'hee,  4'sd1, JT_NONE},
        {3'd0, 8'h10, 8'hfc,  4'sd1, JT_NONE}, {3'd0, 8'h16, 8'hfe,  4'sd1, JT_NONE},
        {3'd0, 8'h20, 8'he0,  4'sd1, JT_NONE}, {3'd0, 8'h40, 8'hf0,  4'sd1, JT_RELB},
        {3'd0, 8'h50, 8'hfc,  4'sd1, JT_NONE}, {3'd0, 8'h54, 8'hfd,  4'sd1, JT_RET},
        {3'd0, 8'h55, 8'hff,  4'sd1, JT_RELB}, {3'd0, 8'h57, 8'hff,  4'sd1, JT_NONE},
        {3'd0, 8'h58, 8'hfb,  4'sd2, JT_RELW}, {3'd0, 8'h59, 8'hfb,  4'sd1, JT_REG},
        {3'd0, 8'h5a, 8'hfb,  4'sd2, JT_ABS},  {3'd0, 8'h5b, 8'hfb,  4'sd2, JT_IND},
        {3'd0, 8'h60, 8'he8,  4'sd1, JT_NONE}, {3'd0, 8'h68, 8'hfa,  4'sd1, JT_NONE},
        {3'd0, 8'h6a, 8'hfe, -4'sd2, JT_NONE}, {3'd0, 8'h6e, 8'hfe,  4'sd2, JT_NONE},
        {3'd0, 8'h78, 8'hff,  4'sd4, JT_NONE}, {3'd0, 8'h79, 8'hff,  4'sd2, JT_NONE},
        {3'd0, 8'h7a, 8'hff,  4'sd3, JT_NONE}, {3'd0, 8'h7b, 8'hff,  4'sd2, JT_NONE},
        {3'd0, 8'h7c, 8'hfc,  4'sd2, JT_NONE}, {3'd0, 8'h80, 8'h80,  4'sd1, JT_NONE},
        {3'd1, 8'h00, 8'hff, -4'sd3, JT_NONE}, {3'd1, 8'h40, 8'hf0, -4'sd3, JT_NONE},
        {3'd1, 8'h80, 8'hf0,  4'sd1, JT_NONE}, {3'd1, 8'hc0, 8'hc0,  4'sd2, JT_NONE},
        {3'd2, 8'h00, 8'h20,  4'sd2, JT_NONE}, {3'd2, 8'h20, 8'h20,  4'sd3, JT_NONE},
        {3'd3, 8'h69, 8'hfb,  4'sd2, JT_NONE}, {3'd3, 8'h6b, 8'hff, -4'sd4, JT_NONE},
        {3'd3, 8'h6f, 8'hff,  4'sd3, JT_NONE}, {3'd3, 8'h78, 8'hff,  4'sd5, JT_NONE},
        {3'd4, 8'h00, 8'h78,  4'sd3, JT_NONE}, {3'd4, 8'h20, 8'h78,  4'sd4, JT_NONE}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    in_word_t  instr_queue[$];
    out_word_t predicted_results[$];
    out_word_t wanted;

    int accepted_words  = 0;
    int results_checked = 0;
    int total_words     = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int send_gap        = 0;
    int stall_left      = 0;
    int hold_left       = 0;
    logic hold_done     = 1'b0;

    wire quiet = (accepted_words + QUIET_TAIL >= total_words);

    next_pc_length_branch_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // code bit 0 picks the sense, bits 3..1 pick the flag combination
    function automatic logic branch_condition_met(input logic [3:0] code,
                                                  input logic [7:0] flags);
        logic n;
        logic z;
        logic v;
        logic c;
        logic sel;
        n = flags[3];
        z = flags[2];
        v = flags[1];
        c = flags[0];
        case (code[3:1])
            3'd0: sel = 1'b0;
            3'd1: sel = z | c;
            3'd2: sel = c;
            3'd3: sel = z;
            3'd4: sel = v;
            3'd5: sel = n;
            3'd6: sel = n ^ v;
            default: sel = (n ^ v) | z;
        endcase
        return code[0] ? sel : !sel;
    endfunction

    function automatic out_word_t decode_next_pc(input in_word_t w);
        out_word_t         r;
        logic [2:0]        tsel;
        logic [7:0]        opbyte;
        logic [25:0]       row;
        logic              found;
        logic              stop;
        logic              matched;
        logic              taken;
        logic signed [3:0] len;
        jump_t             jt;
        logic [7:0]        b0;
        logic [7:0]        b1;
        logic [23:0]       pc;
        r       = '0;
        tsel    = 3'd0;
        stop    = 1'b0;
        matched = 1'b0;
        len     = 4'sd0;
        jt      = JT_NONE;
        b0      = w.instruction_bytes[31:24];
        b1      = w.instruction_bytes[23:16];
        pc      = w.pc_address;
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            if (!stop)
            begin
                opbyte = w.instruction_bytes[31 - 8 * lvl -: 8];
                found  = 1'b0;
                for (int i = 0; i < NUM_ROWS; i++)
                begin
                    row = OPCODE_ROWS[i];
                    if (!found && row[25:23] == tsel && (opbyte & row[14:7]) == row[22:15])
                    begin
                        found = 1'b1;
                        len   = row[6:3];
                        jt    = jump_t'(row[2:0]);
                    end
                end
                if (!found)
                begin
                    stop = 1'b1;
                end
                else if (len < 0)
                begin
                    tsel = 3'(-len);
                end
                else
                begin
                    matched = 1'b1;
                    stop    = 1'b1;
                end
            end
        end
        if (!matched)
        begin
            r.target_kind = KIND_UNDECODE;
            return r;
        end
        r.target_kind  = KIND_RESOLVED;
        r.length_words = len[2:0];
        case (jt)
            JT_ABS:
            begin
                r.next_address = w.instruction_bytes[23:0];
            end
            JT_IND:
            begin
                r.target_kind    = KIND_VECTOR;
                r.vector_address = b1;
            end
            JT_RET:
            begin
                r.target_kind = KIND_RETURN;
            end
            JT_REG:
            begin
                r.target_kind    = KIND_REGISTER;
                r.register_index = b1[6:4];
            end
            JT_RELB:
            begin
                taken          = (b0 == OP_BSR_BYTE) || branch_condition_met(b0[3:0], w.ccr);
                r.branch_taken = taken;
                r.next_address = pc + 24'd2 + (taken ? {{16{b1[7]}}, b1} : 24'd0);
            end
            JT_RELW:
            begin
                taken          = (b0 == OP_BSR_WORD) || branch_condition_met(b1[7:4], w.ccr);
                r.branch_taken = taken;
                r.next_address = pc + 24'd4 + (taken ?
                    {{8{w.instruction_bytes[15]}}, w.instruction_bytes[15:0]} : 24'd0);
            end
            default:
            begin
                r.next_address = pc + {20'd0, len[2:0], 1'b0};
            end
        endcase
        return r;
    endfunction

    task automatic queue_instruction(input logic [23:0] pc, input logic [31:0] ib,
                                     input logic [7:0] flags);
        in_word_t w;
        w.pc_address        = pc;
        w.instruction_bytes = ib;
        w.ccr               = flags;
        instr_queue.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // sender: bursts of idle words, none in the tail
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            in_data        <= '0;
            send_gap       <= 0;
            accepted_words <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_results.push_back(decode_next_pc(in_data));
                accepted_words <= accepted_words + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (!quiet && $urandom_range(0, 5) == 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 3);
                end
                else if (instr_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= instr_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off to fill the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_checked >= 120)
        begin
            out_ready <= 1'b0;
            hold_left <= 47;
            hold_done <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_checked <= results_checked + 1;
            if (predicted_results.size() == 0)
            begin
                $error("result word with nothing expected: %0h", out_data);
                error_count++;
            end
            else
            begin
                wanted = predicted_results.pop_front();
                check_field("target_kind", 32'(wanted.target_kind),
                            32'(out_data.target_kind));
                check_field("next_address", 32'(wanted.next_address),
                            32'(out_data.next_address));
                check_field("register_index", 32'(wanted.register_index),
                            32'(out_data.register_index));
                check_field("vector_address", 32'(wanted.vector_address),
                            32'(out_data.vector_address));
                check_field("branch_taken", 32'(wanted.branch_taken),
                            32'(out_data.branch_taken));
                check_field("length_words", 32'(wanted.length_words),
                            32'(out_data.length_words));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        logic [31:0] ib;
        logic [23:0] pc_word;
        logic [7:0]  ccr_word;

        // directed: extremes, each jump type, condition senses, prefix chains
        queue_instruction(24'h000000, 32'h0000_0000, 8'h00);
        queue_instruction(24'hffffff, 32'hffff_ffff, 8'hff);
        queue_instruction(24'h000000, 32'h4080_0000, 8'h00);
        queue_instruction(24'h000100, 32'h417f_0000, 8'h0f);
        queue_instruction(24'h000200, 32'h4210_0000, 8'h00);
        queue_instruction(24'h000200, 32'h4310_0000, 8'h04);
        queue_instruction(24'h000300, 32'h4f20_0000, 8'hf8);
        queue_instruction(24'h000001, 32'h55fe_0000, 8'h00);
        queue_instruction(24'h001000, 32'h5800_8000, 8'h00);
        queue_instruction(24'h001000, 32'h5830_7fff, 8'h00);
        queue_instruction(24'hfffffe, 32'h5c00_7ffe, 8'h00);
        queue_instruction(24'h123456, 32'h5aab_cdef, 8'h00);
        queue_instruction(24'h000400, 32'h5ba5_0000, 8'h00);
        queue_instruction(24'h000500, 32'h59f0_0000, 8'h00);
        queue_instruction(24'h000600, 32'h5670_0000, 8'h00);
        queue_instruction(24'hfffffa, 32'h7800_0000, 8'h00);
        queue_instruction(24'h000700, 32'h0100_6b20, 8'h00);
        queue_instruction(24'h000700, 32'h0140_7800, 8'h00);
        queue_instruction(24'h000700, 32'h0100_6d00, 8'h00);
        queue_instruction(24'h000800, 32'h01c0_0000, 8'h00);
        queue_instruction(24'h000800, 32'h0110_0000, 8'h00);
        queue_instruction(24'h000800, 32'h0100_6b08, 8'h00);
        queue_instruction(24'h000800, 32'h0100_0000, 8'h00);
        queue_instruction(24'h000900, 32'h6a20_0000, 8'h00);
        queue_instruction(24'h000900, 32'h6b00_0000, 8'h00);

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            pick     = $urandom_range(0, 9);
            ib       = $urandom;
            pc_word  = 24'($urandom);
            ccr_word = 8'($urandom);
            if ($urandom_range(0, 7) == 0)
                pc_word[23:8] = 16'hffff;
            case (pick)
                2, 3:
                begin
                    // well-formed prefix chains with random tails
                    ib[31:24] = 8'h01;
                    case ($urandom_range(0, 4))
                        0: ib[23:16] = 8'h00;
                        1: ib[23:20] = 4'h4;
                        2: ib[23:20] = 4'h8;
                        3: ib[23:22] = 2'b11;
                        default: ;
                    endcase
                    case ($urandom_range(0, 5))
                        0: ib[15:8] = 8'h69;
                        1: ib[15:8] = 8'h6d;
                        2: ib[15:8] = 8'h6b;
                        3: ib[15:8] = 8'h6f;
                        4: ib[15:8] = 8'h78;
                        default: ;
                    endcase
                    if ($urandom_range(0, 1) == 1)
                        ib[6:3] = ($urandom_range(0, 1) == 1) ? 4'b0100 : 4'b0000;
                end
                4:
                begin
                    ib[31:24] = ($urandom_range(0, 1) == 1) ? 8'h6a : 8'h6b;
                end
                5, 6, 7, 8:
                begin
                    case ($urandom_range(0, 3))
                        0: ib[31:28] = 4'h4;
                        1: ib[31:28] = 4'h5;
                        2: ib[31:24] = OP_BSR_BYTE;
                        default: ib[31:24] = ($urandom_range(0, 1) == 1) ? 8'h58 : OP_BSR_WORD;
                    endcase
                end
                9:
                begin
                    ib[31] = 1'b0;
                end
                default: ;
            endcase
            queue_instruction(pc_word, ib, ccr_word);
        end
        total_words = instr_queue.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (instr_queue.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0 && predicted_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
